[hw/rtl/sts_pkg.sv]
package sts_pkg;

    // Operation codes carried in s_axis_tuser
    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_CLEAR  = 3'd1;
    localparam logic [2:0] OP_APPEND = 3'd2;
    localparam logic [2:0] OP_REMOVE = 3'd3;
    localparam logic [2:0] OP_START  = 3'd4;
    localparam logic [2:0] OP_PAUSE  = 3'd5;

    // Status codes returned with each result word
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    // Field widths fixed by the word layout
    localparam int ID_W    = 16;
    localparam int DWELL_W = 32;
    localparam int ENTRY_W = ID_W + DWELL_W;

    // Sequencer states, one-hot
    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_TK_WAIT  = 10'b00_0000_0010,
        S_TK_CHK   = 10'b00_0000_0100,
        S_ACT_WAIT = 10'b00_0000_1000,
        S_ACT      = 10'b00_0001_0000,
        S_RM_WAIT  = 10'b00_0010_0000,
        S_RM_CMP   = 10'b00_0100_0000,
        S_SH_WAIT  = 10'b00_1000_0000,
        S_SH_WR    = 10'b01_0000_0000,
        S_DONE     = 10'b10_0000_0000
    } state_t;

endpackage

[hw/rtl/sts_ram.sv]
module sts_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[hw/rtl/scene_tour_sequencer_unit.sv]
// Scene tour sequencer.
// Input words arrive on s_axis: the opcode in tuser (tick, clear, append,
// remove by id, start, pause), scene id and dwell in tdata. Every accepted
// word gives exactly one result word on m_axis: a load request flag in tuser,
// and the scene to load, a status code, the running flag and the entry count
// in tdata.
// The tour table sits in one synchronous RAM of TOUR_DEPTH entries (id and
// dwell side by side) with a registered read. The result is registered in
// the same cycle that the sequencer returns to idle. Clear, append, start,
// pause and a tick that needs no table read go straight to the result. A
// tick that reads the table activates entry 0 when none is active; else it
// checks the active entry's dwell and, once that has run out, activates the
// next entry. An activation requests the entry's scene. A remove searches
// entry by entry up to the match, then shifts the rest of the table down.
// One word is worked on at a time; s_axis_tready is high while the sequencer
// is idle, including while a finished result waits in the output register.
// When m_axis_tready is low the result word holds; a following word is
// still accepted and processed, and its result waits until the output
// register frees.
// Reset empties the table, stops the tour and clears the output valid.
module scene_tour_sequencer_unit
    import sts_pkg::*;
#(
    parameter int TOUR_DEPTH = 16,
    localparam int IDX_W = $clog2(TOUR_DEPTH),
    localparam int CNT_W = $clog2(TOUR_DEPTH + 1),
    localparam int OUT_W = ((ID_W + 3 + CNT_W + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,

    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // fields from bit 0: scene_id[15:0], dwell_ticks[47:16]
    input  logic [47:0]      s_axis_tdata,
    // fields from bit 0: opcode[2:0]
    input  logic [2:0]       s_axis_tuser,

    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // fields from bit 0: load_scene[15:0], status[17:16], is_running[18],
    // entry_count[18+CNT_W:19], zero fill
    output logic [OUT_W-1:0] m_axis_tdata,
    // fields from bit 0: load_request[0]
    output logic             m_axis_tuser
);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   cur_reg, cur_next;
    logic               active_reg, active_next;
    logic               running_reg, running_next;
    logic [DWELL_W-1:0] elapsed_reg, elapsed_next;
    logic [IDX_W-1:0]   addr_reg, addr_next;
    logic [IDX_W-1:0]   rm_idx_reg, rm_idx_next;
    logic [ID_W-1:0]    key_reg, key_next;
    logic               res_req_reg, res_req_next;
    logic [ID_W-1:0]    res_scene_reg, res_scene_next;
    logic [1:0]         res_status_reg, res_status_next;
    logic               m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]   out_data_reg, out_data_next;
    logic               out_user_reg, out_user_next;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic [ENTRY_W-1:0] rd_data;

    logic               in_accept;
    logic [2:0]         in_op;
    logic [ID_W-1:0]    in_id;
    logic [DWELL_W-1:0] in_dwell;
    logic [ID_W-1:0]    rd_id;
    logic [DWELL_W-1:0] rd_dwell;
    logic [DWELL_W-1:0] elapsed_inc;
    logic [CNT_W-1:0]   addr_plus1;
    logic [CNT_W-1:0]   cur_plus1;

    sts_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TOUR_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (addr_reg),
        .rd_data (rd_data)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign in_op         = s_axis_tuser;
    assign in_id         = s_axis_tdata[ID_W-1:0];
    assign in_dwell      = s_axis_tdata[ENTRY_W-1:ID_W];
    assign rd_id         = rd_data[ID_W-1:0];
    assign rd_dwell      = rd_data[ENTRY_W-1:ID_W];

    // Saturating elapsed count of the active entry
    assign elapsed_inc = (active_reg && (elapsed_reg != '1)) ? elapsed_reg + 1'b1
                                                             : elapsed_reg;
    assign addr_plus1  = CNT_W'(addr_reg) + 1'b1;
    assign cur_plus1   = CNT_W'(cur_reg) + 1'b1;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    // Sequencer: decode the word, walk the table, write back
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        cur_next        = cur_reg;
        active_next     = active_reg;
        running_next    = running_reg;
        elapsed_next    = elapsed_reg;
        addr_next       = addr_reg;
        rm_idx_next     = rm_idx_reg;
        key_next        = key_reg;
        res_req_next    = res_req_reg;
        res_scene_next  = res_scene_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg;
        out_data_next   = out_data_reg;
        out_user_next   = out_user_reg;
        wr_en           = 1'b0;
        wr_addr         = addr_reg;
        wr_data         = rd_data;

        // Drop the result word once taken
        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    res_req_next    = 1'b0;
                    res_scene_next  = '0;
                    res_status_next = ST_OK;
                    state_next      = S_DONE;
                    case (in_op)
                        OP_TICK:
                        begin
                            elapsed_next = elapsed_inc;
                            if (running_reg)
                            begin
                                if (count_reg == '0)
                                begin
                                    running_next = 1'b0;
                                    active_next  = 1'b0;
                                end
                                else if (!active_reg || (CNT_W'(cur_reg) >= count_reg))
                                begin
                                    addr_next  = '0;
                                    state_next = S_ACT_WAIT;
                                end
                                else
                                begin
                                    addr_next  = cur_reg;
                                    state_next = S_TK_WAIT;
                                end
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next  = '0;
                            cur_next    = '0;
                            active_next = 1'b0;
                        end
                        OP_APPEND:
                        begin
                            if (count_reg >= CNT_W'(TOUR_DEPTH))
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = count_reg[IDX_W-1:0];
                                wr_data    = {in_dwell, in_id};
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = ST_NOT_FOUND;
                            end
                            else
                            begin
                                key_next   = in_id;
                                addr_next  = '0;
                                state_next = S_RM_WAIT;
                            end
                        end
                        OP_START:
                        begin
                            running_next = 1'b1;
                        end
                        OP_PAUSE:
                        begin
                            running_next = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_TK_WAIT:
            begin
                state_next = S_TK_CHK;
            end

            // Retire the active entry once its dwell has run out
            S_TK_CHK:
            begin
                state_next = S_DONE;
                if (elapsed_reg > rd_dwell)
                begin
                    active_next = 1'b0;
                    if (count_reg > CNT_W'(1))
                    begin
                        addr_next  = (cur_plus1 >= count_reg) ? '0 : cur_plus1[IDX_W-1:0];
                        state_next = S_ACT_WAIT;
                    end
                end
            end

            S_ACT_WAIT:
            begin
                state_next = S_ACT;
            end

            // Activate the entry at addr and request its scene
            S_ACT:
            begin
                cur_next       = addr_reg;
                active_next    = 1'b1;
                elapsed_next   = '0;
                res_req_next   = 1'b1;
                res_scene_next = rd_id;
                state_next     = S_DONE;
            end

            S_RM_WAIT:
            begin
                state_next = S_RM_CMP;
            end

            // Search for the first matching id
            S_RM_CMP:
            begin
                if (rd_id == key_reg)
                begin
                    rm_idx_next = addr_reg;
                    if (addr_plus1 < count_reg)
                    begin
                        addr_next  = addr_plus1[IDX_W-1:0];
                        state_next = S_SH_WAIT;
                    end
                    else
                    begin
                        // Last entry matched: nothing to shift
                        count_next = count_reg - 1'b1;
                        if (active_reg)
                        begin
                            if (addr_reg == cur_reg)
                            begin
                                active_next = 1'b0;
                                cur_next    = '0;
                            end
                            else if (addr_reg < cur_reg)
                            begin
                                cur_next = cur_reg - 1'b1;
                            end
                        end
                        state_next = S_DONE;
                    end
                end
                else if (addr_plus1 < count_reg)
                begin
                    addr_next  = addr_plus1[IDX_W-1:0];
                    state_next = S_RM_WAIT;
                end
                else
                begin
                    res_status_next = ST_NOT_FOUND;
                    state_next      = S_DONE;
                end
            end

            S_SH_WAIT:
            begin
                state_next = S_SH_WR;
            end

            // Move the entry at addr down by one, then close out the remove
            S_SH_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = addr_reg - 1'b1;
                wr_data = rd_data;
                if (addr_plus1 < count_reg)
                begin
                    addr_next  = addr_plus1[IDX_W-1:0];
                    state_next = S_SH_WAIT;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    if (active_reg)
                    begin
                        if (rm_idx_reg == cur_reg)
                        begin
                            active_next = 1'b0;
                            cur_next    = '0;
                        end
                        else if (rm_idx_reg < cur_reg)
                        begin
                            cur_next = cur_reg - 1'b1;
                        end
                    end
                    state_next = S_DONE;
                end
            end

            // Load the result word once the output register is free
            S_DONE:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next  = 1'b1;
                    out_user_next = res_req_reg;
                    out_data_next = OUT_W'({count_reg, running_reg,
                                            res_status_reg, res_scene_reg});
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            cur_reg     <= '0;
            active_reg  <= 1'b0;
            running_reg <= 1'b0;
            elapsed_reg <= '0;
            addr_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            cur_reg     <= cur_next;
            active_reg  <= active_next;
            running_reg <= running_next;
            elapsed_reg <= elapsed_next;
            addr_reg    <= addr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rm_idx_reg     <= rm_idx_next;
        key_reg        <= key_next;
        res_req_reg    <= res_req_next;
        res_scene_reg  <= res_scene_next;
        res_status_reg <= res_status_next;
        out_data_reg   <= out_data_next;
        out_user_reg   <= out_user_next;
    end

    // Table never holds more entries than it has rows
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TOUR_DEPTH))
        else $error("tour count exceeds table depth");

    // An active entry always lies inside the table
    assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (CNT_W'(cur_reg) < count_reg))
        else $error("active entry outside the table");

    // Outside idle, a table write never lands on the row being read
    assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && (state_reg != S_IDLE)) |-> (wr_addr != addr_reg))
        else $error("table write collides with read row");

    // An accepted word always leaves the idle state
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("sequencer stayed idle after accepting a word");

endmodule

[tb/sv/tb.sv]
module tb;
    import sts_pkg::*;

    localparam int DEPTH = 16;
    localparam int RES_W = 24;

    // One expected result word, fields in the order they sit on m_axis
    typedef struct packed {
        logic        load_request;
        logic [15:0] load_scene;
        logic [1:0]  status;
        logic        is_running;
        logic [4:0]  entry_count;
    } tour_result_t;

    logic             clk;
    logic             rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    // fields from bit 0: scene_id[15:0], dwell_ticks[47:16]
    logic [47:0]      s_axis_tdata;
    // fields from bit 0: opcode[2:0]
    logic [2:0]       s_axis_tuser;
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    // fields from bit 0: load_scene[15:0], status[17:16], is_running[18],
    // entry_count[23:19]
    logic [RES_W-1:0] m_axis_tdata;
    // fields from bit 0: load_request[0]
    logic             m_axis_tuser;

    // Shadow copy of the tour table and sequencer state
    logic [15:0]  tbl_id [DEPTH];
    logic [31:0]  tbl_dwell [DEPTH];
    logic [4:0]   tbl_count;
    logic [3:0]   cur_idx;
    logic         cur_active;
    logic         tour_on;
    logic [31:0]  dwell_elapsed;

    tour_result_t expected_results[$];
    int           err_count;
    int           words_checked;
    bit           calm;
    int           rx_stall;
    int           rx_roll;
    tour_result_t want;

    scene_tour_sequencer_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    // Apply one operation to the shadow state and return the result word
    function automatic tour_result_t predict_tour_step(input logic [2:0] op,
                                                       input logic [15:0] id,
                                                       input logic [31:0] dwell);
        tour_result_t r;
        int hit;
        int go;
        r = '0;
        go = -1;
        case (op)
            OP_TICK:
            begin
                if (cur_active && dwell_elapsed != 32'hFFFF_FFFF)
                    dwell_elapsed = dwell_elapsed + 32'd1;
                if (tour_on)
                begin
                    if (tbl_count == 0)
                    begin
                        tour_on = 1'b0;
                        cur_active = 1'b0;
                    end
                    else if (!cur_active || cur_idx >= tbl_count)
                        go = 0;
                    else if (dwell_elapsed > tbl_dwell[cur_idx])
                    begin
                        cur_active = 1'b0;
                        if (tbl_count > 1)
                            go = (int'(cur_idx) + 1 >= int'(tbl_count)) ? 0
                                 : int'(cur_idx) + 1;
                    end
                end
                // load the chosen entry
                if (go >= 0)
                begin
                    cur_idx = 4'(go);
                    cur_active = 1'b1;
                    dwell_elapsed = '0;
                    r.load_request = 1'b1;
                    r.load_scene = tbl_id[go];
                end
            end
            OP_CLEAR:
            begin
                tbl_count = '0;
                cur_idx = '0;
                cur_active = 1'b0;
            end
            OP_APPEND:
            begin
                if (tbl_count >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    tbl_id[tbl_count[3:0]] = id;
                    tbl_dwell[tbl_count[3:0]] = dwell;
                    tbl_count = tbl_count + 5'd1;
                end
            end
            OP_REMOVE:
            begin
                hit = -1;
                for (int i = 0; i < tbl_count; i++)
                    if (hit < 0 && tbl_id[i] == id)
                        hit = i;
                if (hit < 0)
                    r.status = ST_NOT_FOUND;
                else
                begin
                    // close the gap
                    for (int j = hit; j + 1 < tbl_count; j++)
                    begin
                        tbl_id[j] = tbl_id[j + 1];
                        tbl_dwell[j] = tbl_dwell[j + 1];
                    end
                    tbl_count = tbl_count - 5'd1;
                    if (cur_active)
                    begin
                        if (hit == int'(cur_idx))
                        begin
                            cur_active = 1'b0;
                            cur_idx = '0;
                        end
                        else if (hit < int'(cur_idx))
                            cur_idx = cur_idx - 4'd1;
                    end
                end
            end
            OP_START:
                tour_on = 1'b1;
            OP_PAUSE:
                tour_on = 1'b0;
            default:
                ;
        endcase
        r.is_running = tour_on;
        r.entry_count = tbl_count;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Mostly a small pool so ids repeat and removes hit
    function automatic logic [15:0] pick_scene();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 16'($urandom_range(0, 7));
        if (r < 60)
            return 16'hFFFF;
        return 16'($urandom_range(0, 65535));
    endfunction

    // Mostly short dwells so the tour advances often
    function automatic logic [31:0] pick_dwell();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 3);
        if (r < 90)
            return $urandom_range(4, 20);
        if (r < 98)
            return $urandom();
        return 32'hFFFF_FFFF;
    endfunction

    function automatic logic [15:0] pick_removal();
        if (tbl_count > 0 && $urandom_range(0, 3) != 0)
            return tbl_id[4'($urandom_range(0, tbl_count - 1))];
        return pick_scene();
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] exp_v,
                                   input logic [31:0] got_v);
        $display("mismatch in %s at result word %0d: expected %0h, got %0h",
                 what, words_checked, exp_v, got_v);
        err_count++;
    endtask

    // Send one word, wait for accept, then record its expected result
    task automatic send_word(input logic [2:0] op, input logic [15:0] id,
                             input logic [31:0] dwell);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {dwell, id};
        do
            @(posedge clk);
        while (!s_axis_tready);
        expected_results.push_back(predict_tour_step(op, id, dwell));
    endtask

    // Hold the input until every result has come back
    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_random_op(input int tick_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < tick_pct)
            send_word(OP_TICK, 16'($urandom_range(0, 65535)), $urandom());
        else if (r < tick_pct + (100 - tick_pct) * 3 / 10)
            send_word(OP_REMOVE, pick_removal(), $urandom());
        else if (r < tick_pct + (100 - tick_pct) * 6 / 10)
            send_word(OP_APPEND, pick_scene(), pick_dwell());
        else if (r < tick_pct + (100 - tick_pct) * 75 / 100)
            send_word(OP_PAUSE, 16'($urandom_range(0, 65535)), $urandom());
        else if (r < tick_pct + (100 - tick_pct) * 93 / 100)
            send_word(OP_START, 16'($urandom_range(0, 65535)), $urandom());
        else
            send_word(OP_CLEAR, 16'($urandom_range(0, 65535)), $urandom());
    endtask

    // Field extremes, full table, missing id, advance, pause, removal cases
    task automatic test_directed();
        calm = 1'b0;
        send_word(OP_TICK, 16'h0000, 32'h0000_0000);
        send_word(OP_START, 16'hFFFF, 32'hFFFF_FFFF);
        // running with an empty table stops on the next tick
        send_word(OP_TICK, 16'h0000, 32'h0000_0000);
        send_word(OP_APPEND, 16'h0000, 32'h0000_0000);
        send_word(OP_APPEND, 16'hFFFF, 32'hFFFF_FFFF);
        for (int i = 2; i < DEPTH; i++)
            send_word(OP_APPEND, 16'(16'h0100 + i), 32'd2);
        // append on a full table
        send_word(OP_APPEND, 16'hA5A5, 32'h5A5A_5A5A);
        send_word(OP_REMOVE, 16'h5555, 32'h0000_0000);
        send_word(OP_START, 16'h0000, 32'h0000_0000);
        send_word(OP_TICK, 16'h0000, 32'h0000_0000);
        // zero dwell: the second tick moves to the next scene
        send_word(OP_TICK, 16'h0000, 32'h0000_0000);
        send_word(OP_PAUSE, 16'h0000, 32'h0000_0000);
        // elapsed time keeps counting while paused
        send_word(OP_TICK, 16'h0000, 32'h0000_0000);
        send_word(OP_START, 16'h0000, 32'h0000_0000);
        // remove ahead of the active entry, then the active entry itself
        send_word(OP_REMOVE, 16'h0000, 32'h0000_0000);
        send_word(OP_REMOVE, 16'hFFFF, 32'h0000_0000);
        send_word(OP_TICK, 16'h0000, 32'h0000_0000);
        // clear keeps running; the next tick stops the tour
        send_word(OP_CLEAR, 16'h0000, 32'h0000_0000);
        send_word(OP_TICK, 16'h0000, 32'h0000_0000);
    endtask

    // Build a table, start, then mostly ticks with edits mixed in
    task automatic test_tour_sequences(input int n_items);
        int sent;
        int k;
        sent = 0;
        while (sent < n_items)
        begin
            calm = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 3) == 0)
            begin
                send_word(OP_CLEAR, 16'($urandom_range(0, 65535)), $urandom());
                sent++;
            end
            k = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 18)
                : $urandom_range(1, 5);
            repeat (k)
            begin
                send_word(OP_APPEND, pick_scene(), pick_dwell());
                sent++;
            end
            send_word(OP_START, 16'($urandom_range(0, 65535)), $urandom());
            sent++;
            repeat ($urandom_range(10, 50))
            begin
                send_random_op(72);
                sent++;
            end
            if ($urandom_range(0, 7) == 0)
                wait_results_drained();
        end
    endtask

    // Uniform operations with random payloads
    task automatic test_noise(input int n_items);
        calm = 1'b0;
        repeat (n_items)
            send_word(3'($urandom_range(OP_TICK, OP_PAUSE)),
                      16'($urandom_range(0, 65535)), $urandom());
    endtask

    // Heavy append and remove traffic around a running tour
    task automatic test_table_churn(input int n_items);
        int sent;
        sent = 0;
        while (sent < n_items)
        begin
            calm = ($urandom_range(0, 2) == 0);
            repeat ($urandom_range(10, 40))
            begin
                send_random_op(30);
                sent++;
            end
        end
    endtask

    // Receiver side: random stalls, a few of them long
    always @(posedge clk)
    begin
        if (calm)
        begin
            rx_stall = 0;
            m_axis_tready <= 1'b1;
        end
        else if (rx_stall > 0)
        begin
            rx_stall--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            rx_roll = $urandom_range(0, 99);
            if (rx_roll < 20)
            begin
                rx_stall = $urandom_range(0, 2);
                m_axis_tready <= 1'b0;
            end
            else if (rx_roll < 24)
            begin
                rx_stall = $urandom_range(8, 40);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Compare each result word with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected word", 32'h0,
                                32'({m_axis_tdata, m_axis_tuser}));
            else
            begin
                want = expected_results.pop_front();
                if (m_axis_tuser !== want.load_request)
                    report_mismatch("load_request", 32'(want.load_request),
                                    32'(m_axis_tuser));
                if (m_axis_tdata[15:0] !== want.load_scene)
                    report_mismatch("load_scene", 32'(want.load_scene),
                                    32'(m_axis_tdata[15:0]));
                if (m_axis_tdata[17:16] !== want.status)
                    report_mismatch("status", 32'(want.status),
                                    32'(m_axis_tdata[17:16]));
                if (m_axis_tdata[18] !== want.is_running)
                    report_mismatch("is_running", 32'(want.is_running),
                                    32'(m_axis_tdata[18]));
                if (m_axis_tdata[23:19] !== want.entry_count)
                    report_mismatch("entry_count", 32'(want.entry_count),
                                    32'(m_axis_tdata[23:19]));
            end
            words_checked++;
        end
    end

    initial
    begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_TICK;
        m_axis_tready = 1'b0;
        calm = 1'b0;
        rx_stall = 0;
        rx_roll = 0;
        err_count = 0;
        words_checked = 0;
        for (int i = 0; i < DEPTH; i++)
        begin
            tbl_id[i] = '0;
            tbl_dwell[i] = '0;
        end
        tbl_count = '0;
        cur_idx = '0;
        cur_active = 1'b0;
        tour_on = 1'b0;
        dwell_elapsed = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_tour_sequences(1100);
        wait_results_drained();
        test_noise(350);
        test_table_churn(450);

        // drain and let a slow remove finish
        s_axis_tvalid <= 1'b0;
        calm = 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (err_count == 0 && expected_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/sts_pkg.sv
hw/rtl/sts_ram.sv
hw/rtl/scene_tour_sequencer_unit.sv
tb/sv/tb.sv
